[sv/upc_pkg.sv]
// ----------------------------------------------------------------------------
// upc_pkg
// Shared types, character codes and helper functions for the URL percent
// codec: hex digit tests, safe-set tests and the translate result record.
// ----------------------------------------------------------------------------
package upc_pkg;

   typedef enum logic [1:0] {
      CLASS_LOGIN     = 2'd0,
      CLASS_PATH      = 2'd1,
      CLASS_PARAMETER = 2'd2,
      CLASS_QUERY     = 2'd3
   } class_type;

   localparam logic REG_ENCODE_MODE     = 1'b0;
   localparam logic REG_COMPONENT_CLASS = 1'b1;

   localparam logic [1:0] PEND_NONE    = 2'd0;
   localparam logic [1:0] PEND_PERCENT = 2'd1;
   localparam logic [1:0] PEND_DIGIT   = 2'd2;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_UA      = 8'h41;
   localparam logic [7:0] CH_UF      = 8'h46;
   localparam logic [7:0] CH_UZ      = 8'h5A;
   localparam logic [7:0] CH_LA      = 8'h61;
   localparam logic [7:0] CH_LF      = 8'h66;
   localparam logic [7:0] CH_LZ      = 8'h7A;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_QUOTE   = 8'h27;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_AT      = 8'h40;
   localparam logic [7:0] CH_BAR     = 8'h7C;

   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic            last;
      logic [1:0]      next_pending;
      logic [7:0]      next_digit;
   } result_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
             (c >= CH_LA && c <= CH_LF);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      if (c >= CH_0 && c <= CH_9) begin
         v = c - CH_0;
      end else if (c >= CH_LA && c <= CH_LF) begin
         v = c - CH_LA + 8'd10;
      end else begin
         v = c - CH_UA + 8'd10;
      end
      return v[3:0];
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return CH_0 + {4'd0, nib};
      end
      return CH_UA + {4'd0, nib} - 8'd10;
   endfunction

   function automatic logic is_safe(input logic [7:0] c, input class_type cls);
      logic base;
      logic extra;
      base = (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) ||
             (c >= CH_0 && c <= CH_9) || c == CH_MINUS || c == CH_UNDER ||
             c == CH_DOT || c == CH_BANG || c == CH_TILDE || c == CH_STAR ||
             c == CH_QUOTE || c == CH_LPAREN || c == CH_RPAREN;
      unique case (cls)
         CLASS_LOGIN: begin
            extra = c == CH_SEMI || c == CH_AMP || c == CH_EQUAL ||
                    c == CH_PLUS || c == CH_DOLLAR || c == CH_COMMA;
         end
         CLASS_PATH: begin
            extra = c == CH_COLON || c == CH_AT || c == CH_AMP || c == CH_EQUAL ||
                    c == CH_PLUS || c == CH_DOLLAR || c == CH_COMMA || c == CH_BAR;
         end
         CLASS_PARAMETER: begin
            extra = c == CH_COLON || c == CH_AMP || c == CH_PLUS || c == CH_DOLLAR;
         end
         default: begin
            extra = 1'b0;
         end
      endcase
      return base || extra;
   endfunction

endpackage

[sv/upc_translate.sv]
// ----------------------------------------------------------------------------
// upc_translate
// Translates one input byte against the held escape state into zero to three
// output bytes, and computes the escape state that follows it.
// ----------------------------------------------------------------------------
module upc_translate
   import upc_pkg::*;
(
   input  logic       encode_mode,
   input  class_type  component_class,
   input  logic [1:0] pending,
   input  logic [7:0] pending_digit,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output result_type result
);

   logic [2:0][7:0] o;
   logic [1:0]      n;
   logic [1:0]      np;
   logic [7:0]      nd;
   logic            do_fresh;
   logic            b_hex;

   assign b_hex = is_hex(in_byte);

   always_comb begin
      o        = '0;
      n        = 2'd0;
      np       = PEND_NONE;
      nd       = pending_digit;
      do_fresh = 1'b0;
      if (encode_mode) begin
         nd = 8'd0;
         if (is_safe(in_byte, component_class)) begin
            o[0] = in_byte;
            n    = 2'd1;
         end else begin
            o[0] = CH_PERCENT;
            o[1] = hex_char(in_byte[7:4]);
            o[2] = hex_char(in_byte[3:0]);
            n    = 2'd3;
         end
      end else begin
         unique case (pending)
            PEND_PERCENT: begin
               if (b_hex) begin
                  nd = in_byte;
                  np = PEND_DIGIT;
               end else begin
                  o[n]     = CH_PERCENT;
                  n        = n + 2'd1;
                  do_fresh = 1'b1;
               end
            end
            PEND_DIGIT: begin
               if (b_hex) begin
                  o[n] = {hex_value(pending_digit), hex_value(in_byte)};
                  n    = n + 2'd1;
               end else begin
                  o[n]     = CH_PERCENT;
                  n        = n + 2'd1;
                  o[n]     = pending_digit;
                  n        = n + 2'd1;
                  do_fresh = 1'b1;
               end
            end
            default: begin
               do_fresh = 1'b1;
            end
         endcase
         if (do_fresh) begin
            if (in_byte == CH_PERCENT) begin
               np = PEND_PERCENT;
            end else begin
               o[n] = (in_byte == CH_PLUS && component_class == CLASS_QUERY) ?
                      CH_SPACE : in_byte;
               n    = n + 2'd1;
            end
         end
         if (in_last) begin
            if (np != PEND_NONE) begin
               o[n] = CH_PERCENT;
               n    = n + 2'd1;
            end
            if (np == PEND_DIGIT) begin
               o[n] = nd;
               n    = n + 2'd1;
            end
            np = PEND_NONE;
         end
      end
   end

   assign result.bytes        = o;
   assign result.count        = n;
   assign result.last         = in_last;
   assign result.next_pending = np;
   assign result.next_digit   = nd;

endmodule

[sv/url_percent_codec.sv]
// ----------------------------------------------------------------------------
// url_percent_codec
// Streaming URL percent-escape encoder and decoder.
//
// Input bytes arrive on the req_ stream, req_tlast on the final byte of a
// component string. Translated bytes leave on the rsp_ stream, rsp_tlast on
// the final output byte of the string. The csr_ port selects encode or
// decode and the component class; the user must write it only while the
// block idles, and the block itself does not enforce this. Each accepted
// beat is translated in the cycle it is accepted and loads a three-byte
// output buffer, so the first result beat is valid in the next cycle. The
// buffer drains one beat per cycle while the receiver is ready, giving zero
// to three bytes per input beat on the single rsp_ channel; a beat that
// produces nothing, such as a held escape, leaves the buffer empty. A new
// input beat is taken while the last buffered byte is being taken.
// When the receiver stalls, the buffer holds its bytes and req_tready stays
// low until the final buffered byte is being taken. Reset empties the
// buffer, clears any held partial escape, and sets decode mode with the query class.
// ----------------------------------------------------------------------------
module url_percent_codec
   import upc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte [7:0]
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte [7:0]
   output logic       rsp_tlast,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [1:0] csr_wdata
);

   logic            mode_ff;
   class_type       class_ff;
   logic [1:0]      pending_ff, pending_in;
   logic [7:0]      digit_ff, digit_in;
   logic [2:0][7:0] buf_ff, buf_in;
   logic [1:0]      rem_ff, rem_in;
   logic            last_ff, last_in;
   logic            req_acc;
   logic            rsp_acc;
   result_type      result;

   upc_translate u_translate (
      .encode_mode     (mode_ff),
      .component_class (class_ff),
      .pending         (pending_ff),
      .pending_digit   (digit_ff),
      .in_byte         (req_tdata),
      .in_last         (req_tlast),
      .result          (result)
   );

   assign rsp_tvalid = rem_ff != 2'd0;
   assign rsp_tdata  = buf_ff[0];
   assign rsp_tlast  = last_ff && rem_ff == 2'd1;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign req_tready = rem_ff == 2'd0 || (rem_ff == 2'd1 && rsp_tready);
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      pending_in = pending_ff;
      digit_in   = digit_ff;
      buf_in     = buf_ff;
      rem_in     = rem_ff;
      last_in    = last_ff;
      if (req_acc) begin
         pending_in = result.next_pending;
         digit_in   = result.next_digit;
         buf_in     = result.bytes;
         rem_in     = result.count;
         last_in    = result.last;
      end else if (rsp_acc) begin
         buf_in = {8'd0, buf_ff[2], buf_ff[1]};
         rem_in = rem_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         class_ff   <= CLASS_QUERY;
         pending_ff <= PEND_NONE;
         digit_ff   <= 8'd0;
         rem_ff     <= 2'd0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_ENCODE_MODE: begin
                  mode_ff <= csr_wdata[0];
               end
               REG_COMPONENT_CLASS: begin
                  class_ff <= class_type'(csr_wdata);
               end
               default: begin
               end
            endcase
         end
         pending_ff <= pending_in;
         digit_ff   <= digit_in;
         rem_ff     <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      last_ff <= last_in;
   end

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      req_acc && result.count != 2'd0 |=> rsp_tvalid)
      else $error("accepted beat with results left no output pending");

   a_pending_code: assert property (@(posedge clock) disable iff (reset)
      pending_ff == PEND_NONE || pending_ff == PEND_PERCENT ||
      pending_ff == PEND_DIGIT)
      else $error("held escape count out of range");

   a_encode_clears: assert property (@(posedge clock) disable iff (reset)
      req_acc && mode_ff |=> pending_ff == PEND_NONE)
      else $error("encode beat left a partial escape held");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tlast |=> pending_ff == PEND_NONE)
      else $error("final beat left a partial escape held");

endmodule

[bench/url_percent_codec_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// url_percent_codec_tb
// Self-checking bench for the URL percent codec. A directed stimulus table
// covers escapes, broken escapes, end-of-string flushes, byte extremes and
// every component class in encode mode. Random strings of well-formed and
// broken escapes follow, with random sender and receiver idling. Every output
// beat is checked against table bytes or a predictor of the translation.
// ----------------------------------------------------------------------------
module url_percent_codec_tb;
   import upc_pkg::*;

   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          ITEMS_PER_PHASE = 33;
   localparam int          PHASE_COUNT = 12;
   localparam logic [1:0]  MODE_DECODE = 2'd0;
   localparam logic [1:0]  MODE_ENCODE = 2'd1;
   localparam logic [1:0]  MODE_ENCODE_WIDE = 2'd3;
   localparam logic [7:0]  CH_LG = 8'h67;

   typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      logic            index;
      logic [1:0]      wdata;
      logic [7:0]      data;
      logic            last;
      int              exp_count;
      logic [2:0][7:0] exp_bytes;
   } stim_row_type;

   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
   } out_burst_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;    // in_byte [7:0]
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // out_byte [7:0]
   logic       rsp_tlast;
   logic       csr_we = 1'b0;
   logic       csr_index = 1'b0;
   logic [1:0] csr_wdata = 2'd0;

   logic       mode_encode = 1'b0;
   class_type  cur_class = CLASS_QUERY;
   logic [1:0] held_count = PEND_NONE;
   logic [7:0] held_digit = 8'd0;

   out_beat_type  expected_beats[$];
   stim_row_type  directed_rows[$];
   int         tx_idle_pct = 13;
   int         rx_idle_pct = 45;
   int         error_count = 0;
   int         beats_sent = 0;
   int         beats_checked = 0;
   int         strings_sent = 0;
   int         idle_cycles = 0;

   url_percent_codec DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic is_hex_digit(input logic [7:0] c);
      return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
             (c >= CH_LA && c <= CH_LF);
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] v;
      if (c <= CH_9) begin
         v = c - CH_0;
      end else if (c >= CH_LA) begin
         v = c - CH_LA + 8'd10;
      end else begin
         v = c - CH_UA + 8'd10;
      end
      return v[3:0];
   endfunction

   function automatic logic [7:0] hex_glyph(input logic [3:0] n);
      return (n < 4'd10) ? CH_0 + 8'(n) : CH_UA + 8'(n) - 8'd10;
   endfunction

   function automatic logic safe_char(input logic [7:0] c, input class_type cls);
      logic [7:0] marks[$];
      logic [7:0] extra[$];
      if ((c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) ||
          (c >= CH_0 && c <= CH_9)) begin
         return 1'b1;
      end
      marks = '{CH_MINUS, CH_UNDER, CH_DOT, CH_BANG, CH_TILDE, CH_STAR,
                CH_QUOTE, CH_LPAREN, CH_RPAREN};
      case (cls)
         CLASS_LOGIN: begin
            extra = '{CH_SEMI, CH_AMP, CH_EQUAL, CH_PLUS, CH_DOLLAR, CH_COMMA};
         end
         CLASS_PATH: begin
            extra = '{CH_COLON, CH_AT, CH_AMP, CH_EQUAL, CH_PLUS, CH_DOLLAR,
                      CH_COMMA, CH_BAR};
         end
         CLASS_PARAMETER: begin
            extra = '{CH_COLON, CH_AMP, CH_PLUS, CH_DOLLAR};
         end
         default: begin
            extra = {};
         end
      endcase
      foreach (marks[i]) if (marks[i] == c) return 1'b1;
      foreach (extra[i]) if (extra[i] == c) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void append_byte(inout out_burst_type r, input logic [7:0] c);
      r.bytes[r.count] = c;
      r.count = r.count + 2'd1;
   endfunction

   function automatic void take_fresh(inout out_burst_type r, input logic [7:0] c);
      if (c == CH_PERCENT) begin
         held_count = PEND_PERCENT;
      end else begin
         append_byte(r, (c == CH_PLUS && cur_class == CLASS_QUERY) ? CH_SPACE : c);
      end
   endfunction

   // Advances the held-escape state by one input byte and returns its output.
   function automatic out_burst_type translate_beat(input logic [7:0] b, input logic l);
      out_burst_type r;
      r = '0;
      if (mode_encode) begin
         held_count = PEND_NONE;
         held_digit = 8'd0;
         if (safe_char(b, cur_class)) begin
            append_byte(r, b);
         end else begin
            append_byte(r, CH_PERCENT);
            append_byte(r, hex_glyph(b[7:4]));
            append_byte(r, hex_glyph(b[3:0]));
         end
      end else begin
         if (held_count == PEND_PERCENT) begin
            if (is_hex_digit(b)) begin
               held_digit = b;
               held_count = PEND_DIGIT;
            end else begin
               append_byte(r, CH_PERCENT);
               held_count = PEND_NONE;
               take_fresh(r, b);
            end
         end else if (held_count == PEND_DIGIT) begin
            if (is_hex_digit(b)) begin
               append_byte(r, {nibble_of(held_digit), nibble_of(b)});
               held_count = PEND_NONE;
            end else begin
               append_byte(r, CH_PERCENT);
               append_byte(r, held_digit);
               held_count = PEND_NONE;
               take_fresh(r, b);
            end
         end else begin
            held_count = PEND_NONE;
            take_fresh(r, b);
         end
         if (l) begin
            if (held_count != PEND_NONE) append_byte(r, CH_PERCENT);
            if (held_count == PEND_DIGIT) append_byte(r, held_digit);
            held_count = PEND_NONE;
         end
      end
      return r;
   endfunction

   function automatic stim_row_type beat_row(input logic [7:0] data, input logic last,
                                             input int n, input logic [7:0] b0 = 8'd0,
                                             input logic [7:0] b1 = 8'd0,
                                             input logic [7:0] b2 = 8'd0);
      stim_row_type r;
      r.kind = ROW_BEAT;
      r.index = REG_ENCODE_MODE;
      r.wdata = 2'd0;
      r.data = data;
      r.last = last;
      r.exp_count = n;
      r.exp_bytes[0] = b0;
      r.exp_bytes[1] = b1;
      r.exp_bytes[2] = b2;
      return r;
   endfunction

   function automatic stim_row_type write_row(input logic index, input logic [1:0] value);
      stim_row_type r;
      r = beat_row(8'd0, 1'b0, -1);
      r.kind = ROW_WRITE;
      r.index = index;
      r.wdata = value;
      return r;
   endfunction

   function automatic logic [7:0] rand_hex();
      int v;
      v = $urandom_range(21);
      if (v < 10) return CH_0 + 8'(v);
      if (v < 16) return CH_LA + 8'(v - 10);
      return CH_UA + 8'(v - 16);
   endfunction

   function automatic logic [7:0] rand_non_hex();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      return is_hex_digit(c) ? CH_LG : c;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      if (error_count < 20) begin
         $display("%0t: %s: got %02h, want %02h", $realtime, what, got, want);
      end
      error_count++;
   endtask

   task automatic send_beat(input logic [7:0] b, input logic l, input int typed_count,
                            input logic [2:0][7:0] typed_bytes);
      out_burst_type burst;
      out_beat_type  beat;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst = translate_beat(b, l);
      if (typed_count >= 0) begin
         burst.count = 2'(typed_count);
         burst.bytes = typed_bytes;
      end
      for (int k = 0; k < burst.count; k++) begin
         beat.data = burst.bytes[k];
         beat.last = l && (k == burst.count - 1);
         expected_beats.push_back(beat);
      end
      beats_sent++;
   endtask

   // Stops the sender and waits until every predicted beat has been seen.
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == REG_ENCODE_MODE) begin
         mode_encode = value[0];
      end else begin
         cur_class = class_type'(value);
      end
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      out_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected output beat", rsp_tdata, 8'd0);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_tdata !== want.data) begin
               report_mismatch("out_byte", rsp_tdata, want.data);
            end
            if (rsp_tlast !== want.last) begin
               report_mismatch("out_last", 8'(rsp_tlast), 8'(want.last));
            end
            beats_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d beats outstanding.", expected_beats.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [7:0] text[$];
      int         ntok;
      int         pick;
      int         items_in_phase;
      logic [1:0] mode_value;

      directed_rows.push_back(beat_row(CH_UA, 1'b0, 1, CH_UA));
      directed_rows.push_back(beat_row(CH_PLUS, 1'b0, 1, CH_SPACE));
      directed_rows.push_back(beat_row(CH_PERCENT, 1'b0, 0));
      directed_rows.push_back(beat_row(8'h34, 1'b0, 0));
      directed_rows.push_back(beat_row(8'h31, 1'b1, 1, CH_UA));
      directed_rows.push_back(beat_row(CH_PERCENT, 1'b0, 0));
      directed_rows.push_back(beat_row(CH_UZ, 1'b0, 2, CH_PERCENT, CH_UZ));
      directed_rows.push_back(beat_row(CH_PERCENT, 1'b0, 0));
      directed_rows.push_back(beat_row(CH_LA, 1'b0, 0));
      directed_rows.push_back(beat_row(CH_PERCENT, 1'b0, 2, CH_PERCENT, CH_LA));
      directed_rows.push_back(beat_row(CH_LF, 1'b0, 0));
      directed_rows.push_back(beat_row(CH_UF, 1'b0, 1, 8'hFF));
      directed_rows.push_back(beat_row(CH_PERCENT, 1'b1, 1, CH_PERCENT));
      directed_rows.push_back(beat_row(CH_PERCENT, 1'b0, 0));
      directed_rows.push_back(beat_row(CH_0, 1'b1, 2, CH_PERCENT, CH_0));
      directed_rows.push_back(beat_row(8'hFF, 1'b1, 1, 8'hFF));
      directed_rows.push_back(beat_row(8'h00, 1'b0, 1, 8'h00));
      directed_rows.push_back(beat_row(CH_PERCENT, 1'b0, 0));
      directed_rows.push_back(write_row(REG_COMPONENT_CLASS, CLASS_LOGIN));
      directed_rows.push_back(write_row(REG_ENCODE_MODE, MODE_ENCODE_WIDE));
      directed_rows.push_back(beat_row(8'h00, 1'b0, 3, CH_PERCENT, CH_0, CH_0));
      directed_rows.push_back(beat_row(8'hFF, 1'b1, 3, CH_PERCENT, CH_UF, CH_UF));
      directed_rows.push_back(beat_row(CH_PLUS, 1'b0, 1, CH_PLUS));
      directed_rows.push_back(write_row(REG_COMPONENT_CLASS, CLASS_QUERY));
      directed_rows.push_back(beat_row(CH_PLUS, 1'b0, 3, CH_PERCENT, 8'h32, 8'h42));
      directed_rows.push_back(write_row(REG_COMPONENT_CLASS, CLASS_PATH));
      directed_rows.push_back(beat_row(CH_COLON, 1'b0, -1));
      directed_rows.push_back(write_row(REG_COMPONENT_CLASS, CLASS_PARAMETER));
      directed_rows.push_back(beat_row(CH_AT, 1'b1, -1));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            settle_idle();
            write_reg(directed_rows[i].index, directed_rows[i].wdata);
         end else begin
            send_beat(directed_rows[i].data, directed_rows[i].last,
                      directed_rows[i].exp_count, directed_rows[i].exp_bytes);
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < 4) begin
            tx_idle_pct = 13;
            rx_idle_pct = 45;
         end else if (phase < 8) begin
            tx_idle_pct = 45;
            rx_idle_pct = 13;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         settle_idle();
         mode_value = (phase % 2 == 0) ? MODE_DECODE : MODE_ENCODE;
         if ($urandom_range(1) == 1) mode_value[1] = 1'b1;
         write_reg(REG_ENCODE_MODE, mode_value);
         write_reg(REG_COMPONENT_CLASS, 2'((phase / 2) % 4));
         items_in_phase = 0;
         while (items_in_phase < ITEMS_PER_PHASE) begin
            text.delete();
            ntok = $urandom_range(6, 1);
            for (int t = 0; t < ntok; t++) begin
               pick = $urandom_range(99);
               if (pick < 30) begin
                  text.push_back(CH_PERCENT);
                  text.push_back(rand_hex());
                  text.push_back(rand_hex());
               end else if (pick < 36) begin
                  text.push_back(CH_PERCENT);
                  text.push_back(rand_non_hex());
               end else if (pick < 42) begin
                  text.push_back(CH_PERCENT);
                  text.push_back(rand_hex());
                  text.push_back(rand_non_hex());
               end else if (pick < 50) begin
                  text.push_back(CH_PLUS);
               end else begin
                  text.push_back(8'($urandom_range(255)));
               end
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
               text.push_back(CH_PERCENT);
            end else if (pick < 14) begin
               text.push_back(CH_PERCENT);
               text.push_back(rand_hex());
            end
            foreach (text[k]) begin
               send_beat(text[k], k == text.size() - 1, -1, '0);
            end
            items_in_phase += text.size();
            strings_sent++;
            if ($urandom_range(19) == 0) settle_idle();
         end
      end

      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d input beats in %0d random strings; checked %0d output beats.",
               beats_sent, strings_sent, beats_checked);
      $display("Both modes, all four classes and three idling regimes were exercised.");
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[url_percent_codec.f]
sv/upc_pkg.sv
sv/upc_translate.sv
sv/url_percent_codec.sv
bench/url_percent_codec_tb.sv
